// ===== sv/trl_pkg.sv =====
package trl_pkg;

    localparam int REQ_W        = 2;
    localparam int INDEX_W      = 8;
    localparam int FIELD_TIME_W = 32;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 72;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PREPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNLINK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TAKE    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LINKED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_LINK2 = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ===== sv/trl_ram.sv =====
module trl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ===== sv/timeout_ring_list.sv =====
// result: on m_tvalid from the output register loaded in ST_DONE, after ST_EXEC and, for a
// link into a non-empty list, ST_LINK2; output stalls delay the load
// flow: no new item until ST_DONE loads the last result; the link RAMs read registered,
// and a link into a non-empty list adds ST_LINK2 to write their single write ports again
// reset: rst_n clears control state, then a pass over all ENTRY_COUNT entries clears the member
// flags while s_tready stays low; configuration writes are taken throughout
module timeout_ring_list #(
    parameter int ENTRY_COUNT = 256,
    parameter int TIME_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // entry_index, sent_time, now_time
    input  logic [trl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type
    input  logic [trl_pkg::REQ_W-1:0]           s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // taken_valid, taken_index, is_empty, zero pad
    output logic [trl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status_code
    output logic [trl_pkg::STATUS_W-1:0]        m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [trl_pkg::FIELD_TIME_W-1:0]    cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam int TW    = trl_pkg::FIELD_TIME_W;
    localparam int IW    = trl_pkg::INDEX_W;

    trl_pkg::state_t state_reg, state_next;

    logic [trl_pkg::REQ_W-1:0]    req_reg, req_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [TIME_BITS-1:0]         sent_reg, sent_next;
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic [TIME_BITS-1:0]         limit_reg, limit_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic                         nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]             clr_reg, clr_next;
    logic [IDX_W-1:0]             tail_reg, tail_next;
    logic [IDX_W-1:0]             nbr_reg, nbr_next;
    logic                         res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]             res_taken_reg, res_taken_next;
    logic [trl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         out_valid_reg, out_valid_next;
    logic [trl_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [trl_pkg::STATUS_W-1:0] out_user_reg, out_user_next;

    logic [IW-1:0]          red_idx;
    logic [IDX_W+IW-1:0]    red_ext;
    logic [IDX_W-1:0]       in_idx;
    logic [TIME_BITS+TW-1:0] sent_ext, now_ext, cfg_ext;
    logic [IDX_W+IW-1:0]    taken_ext;
    logic                   in_take, in_link;

    logic                   prev_we, next_we, stamp_we, flag_we;
    logic [IDX_W-1:0]       prev_waddr, next_waddr, stamp_waddr, flag_waddr;
    logic [IDX_W-1:0]       prev_wdata, next_wdata;
    logic                   flag_wdata;
    logic [IDX_W-1:0]       prev_raddr, next_raddr, stamp_raddr, flag_raddr;
    logic [IDX_W-1:0]       prev_rd, next_rd;
    logic [TIME_BITS-1:0]   stamp_rd;
    logic                   flag_rd;

    logic                   is_link, do_link, do_unlink, expired;
    logic [IDX_W-1:0]       uct;
    logic [TIME_BITS-1:0]   age;
    logic                   out_free;

    assign s_tready  = (state_reg == trl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // index reduced modulo the table size by compare and subtract
    always_comb
    begin
        red_idx = s_tdata[IW-1:0];
        for (int k = IW - 1; k >= 0; k--)
        begin
            if (32'(red_idx) >= (32'(ENTRY_COUNT) << k))
            begin
                red_idx = red_idx - IW'(32'(ENTRY_COUNT) << k);
            end
        end
    end

    assign red_ext  = {{IDX_W{1'b0}}, red_idx};
    assign in_idx   = red_ext[IDX_W-1:0];
    assign sent_ext = {{TIME_BITS{1'b0}}, s_tdata[IW+TW-1:IW]};
    assign now_ext  = {{TIME_BITS{1'b0}}, s_tdata[IW+2*TW-1:IW+TW]};
    assign cfg_ext  = {{TIME_BITS{1'b0}}, cfg_data};
    assign in_take  = (s_tuser == trl_pkg::REQ_TAKE);
    assign in_link  = (s_tuser == trl_pkg::REQ_APPEND) || (s_tuser == trl_pkg::REQ_PREPEND);

    // read addresses presented in the accept cycle
    assign prev_raddr  = in_link ? head_reg : (in_take ? head_reg : in_idx);
    assign next_raddr  = in_take ? head_reg : in_idx;
    assign flag_raddr  = in_idx;
    assign stamp_raddr = head_reg;

    assign is_link   = (req_reg == trl_pkg::REQ_APPEND) || (req_reg == trl_pkg::REQ_PREPEND);
    assign uct       = (req_reg == trl_pkg::REQ_TAKE) ? head_reg : idx_reg;
    assign age       = now_reg - stamp_rd;
    assign expired   = nonempty_reg && (age >= limit_reg);
    assign do_link   = is_link && !flag_rd;
    assign do_unlink = ((req_reg == trl_pkg::REQ_UNLINK) && flag_rd)
                    || ((req_reg == trl_pkg::REQ_TAKE) && expired);
    assign taken_ext = {{IW{1'b0}}, res_taken_reg};

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        sent_next       = sent_reg;
        now_next        = now_reg;
        limit_next      = limit_reg;
        head_next       = head_reg;
        nonempty_next   = nonempty_reg;
        clr_next        = clr_reg;
        tail_next       = tail_reg;
        nbr_next        = nbr_reg;
        res_valid_next  = res_valid_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        prev_we         = 1'b0;
        next_we         = 1'b0;
        stamp_we        = 1'b0;
        flag_we         = 1'b0;
        prev_waddr      = idx_reg;
        next_waddr      = idx_reg;
        stamp_waddr     = idx_reg;
        flag_waddr      = idx_reg;
        prev_wdata      = idx_reg;
        next_wdata      = idx_reg;
        flag_wdata      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_ext[TIME_BITS-1:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            trl_pkg::ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_waddr = clr_reg;
                flag_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(ENTRY_COUNT - 1))
                begin
                    state_next = trl_pkg::ST_IDLE;
                end
            end
            trl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = s_tuser;
                    idx_next   = in_idx;
                    sent_next  = sent_ext[TIME_BITS-1:0];
                    now_next   = now_ext[TIME_BITS-1:0];
                    state_next = trl_pkg::ST_EXEC;
                end
            end
            trl_pkg::ST_EXEC:
            begin
                res_valid_next  = 1'b0;
                res_taken_next  = '0;
                res_status_next = trl_pkg::STATUS_OK;
                state_next      = trl_pkg::ST_DONE;
                if (is_link && flag_rd)
                begin
                    res_status_next = trl_pkg::STATUS_LINKED;
                end
                if ((req_reg == trl_pkg::REQ_UNLINK) && !flag_rd)
                begin
                    res_status_next = trl_pkg::STATUS_ABSENT;
                end
                if (do_link)
                begin
                    stamp_we    = 1'b1;
                    stamp_waddr = idx_reg;
                    flag_we     = 1'b1;
                    flag_waddr  = idx_reg;
                    flag_wdata  = 1'b1;
                    if (!nonempty_reg)
                    begin
                        prev_we       = 1'b1;
                        prev_waddr    = idx_reg;
                        prev_wdata    = idx_reg;
                        next_we       = 1'b1;
                        next_waddr    = idx_reg;
                        next_wdata    = idx_reg;
                        head_next     = idx_reg;
                        nonempty_next = 1'b1;
                    end
                    else
                    begin
                        // prev_rd holds the tail here
                        next_we    = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = idx_reg;
                        prev_we    = 1'b1;
                        prev_waddr = head_reg;
                        prev_wdata = idx_reg;
                        tail_next  = prev_rd;
                        nbr_next   = head_reg;
                        if (req_reg == trl_pkg::REQ_PREPEND)
                        begin
                            head_next = idx_reg;
                        end
                        state_next = trl_pkg::ST_LINK2;
                    end
                end
                if (do_unlink)
                begin
                    flag_we    = 1'b1;
                    flag_waddr = uct;
                    flag_wdata = 1'b0;
                    if ((next_rd == uct) || (prev_rd == uct))
                    begin
                        nonempty_next = 1'b0;
                        head_next     = '0;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = next_rd;
                        prev_we    = 1'b1;
                        prev_waddr = next_rd;
                        prev_wdata = prev_rd;
                        if (head_reg == uct)
                        begin
                            head_next = next_rd;
                        end
                    end
                    if (req_reg == trl_pkg::REQ_TAKE)
                    begin
                        res_valid_next = 1'b1;
                        res_taken_next = head_reg;
                    end
                end
            end
            trl_pkg::ST_LINK2:
            begin
                prev_we    = 1'b1;
                prev_waddr = idx_reg;
                prev_wdata = tail_reg;
                next_we    = 1'b1;
                next_waddr = idx_reg;
                next_wdata = nbr_reg;
                state_next = trl_pkg::ST_DONE;
            end
            trl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(trl_pkg::OUT_TDATA_W - IW - 2){1'b0}},
                                      !nonempty_reg, taken_ext[IW-1:0], res_valid_reg};
                    out_user_next  = res_status_reg;
                    state_next     = trl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trl_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trl_pkg::ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        sent_reg       <= sent_next;
        now_reg        <= now_next;
        tail_reg       <= tail_next;
        nbr_reg        <= nbr_next;
        res_valid_reg  <= res_valid_next;
        res_taken_reg  <= res_taken_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    trl_ram #(.WIDTH(IDX_W), .DEPTH(ENTRY_COUNT)) u_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rd)
    );

    trl_ram #(.WIDTH(IDX_W), .DEPTH(ENTRY_COUNT)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rd)
    );

    trl_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRY_COUNT)) u_stamp (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (sent_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rd)
    );

    trl_ram #(.WIDTH(1), .DEPTH(ENTRY_COUNT)) u_flag (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rd)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == trl_pkg::ST_EXEC))
        else $error("accepted item did not enter execute");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg |-> (head_reg == '0))
        else $error("empty list with nonzero head");

    a_relink_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == trl_pkg::ST_EXEC) && is_link && flag_rd)
        |=> ($stable(head_reg) && $stable(nonempty_reg)))
        else $error("relink of a member changed the list");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == trl_pkg::ST_DONE) && !out_valid_reg) |=> out_valid_reg)
        else $error("result not loaded into free output register");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == trl_pkg::ST_EXEC) && (req_reg == trl_pkg::REQ_TAKE) && !nonempty_reg)
        |=> !res_valid_reg)
        else $error("take reported on an empty list");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 280;

    typedef struct packed {
        logic                         taken;
        logic [trl_pkg::INDEX_W-1:0]  taken_idx;
        logic                         empty;
        logic [trl_pkg::STATUS_W-1:0] status;
    } outcome_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [trl_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    logic [trl_pkg::REQ_W-1:0]        s_tuser = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [trl_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic [trl_pkg::STATUS_W-1:0]     m_tuser;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [trl_pkg::FIELD_TIME_W-1:0] cfg_data = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;

    // list mirror used for prediction
    logic [trl_pkg::INDEX_W-1:0]      ring_prev [256];
    logic [trl_pkg::INDEX_W-1:0]      ring_next [256];
    logic [trl_pkg::FIELD_TIME_W-1:0] ring_stamp [256];
    bit                               ring_member [256];
    logic [trl_pkg::INDEX_W-1:0]      ring_head = '0;
    bit                               ring_filled = 1'b0;
    int                               ring_size = 0;
    logic [trl_pkg::FIELD_TIME_W-1:0] timeout_limit = '0;

    outcome_t                         expected_outcomes [$];
    int                               failures = 0;
    int                               burst_left = 0;
    bit                               steady = 1'b0;
    logic [trl_pkg::FIELD_TIME_W-1:0] clock_ms = '0;
    int unsigned                      step_max = 1;
    int                               hold_req = 0;
    int                               hold_seen = 0;
    int                               hold_left = 0;
    int                               stall_clock = 0;
    int                               stall_mode = 0;
    int                               quiet_cycles = 0;

    timeout_ring_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        ring_prev   = '{default: '0};
        ring_next   = '{default: '0};
        ring_stamp  = '{default: '0};
        ring_member = '{default: 1'b0};
    end

    function automatic void ring_insert(input logic [trl_pkg::INDEX_W-1:0] e,
                                        input bit as_head);
        logic [trl_pkg::INDEX_W-1:0] tail;
        if (!ring_filled)
        begin
            ring_prev[e] = e;
            ring_next[e] = e;
            ring_head = e;
            ring_filled = 1'b1;
        end
        else
        begin
            tail = ring_prev[ring_head];
            ring_next[tail] = e;
            ring_prev[ring_head] = e;
            ring_prev[e] = tail;
            ring_next[e] = ring_head;
            if (as_head)
                ring_head = e;
        end
        ring_member[e] = 1'b1;
        ring_size++;
    endfunction

    function automatic void ring_remove(input logic [trl_pkg::INDEX_W-1:0] e);
        logic [trl_pkg::INDEX_W-1:0] p;
        logic [trl_pkg::INDEX_W-1:0] n;
        p = ring_prev[e];
        n = ring_next[e];
        if (n == e || p == e)
        begin
            ring_filled = 1'b0;
            ring_head = '0;
        end
        else
        begin
            ring_next[p] = n;
            ring_prev[n] = p;
            if (ring_head == e)
                ring_head = n;
        end
        ring_member[e] = 1'b0;
        ring_size--;
    endfunction

    function automatic outcome_t predict_list_outcome(
        input logic [trl_pkg::REQ_W-1:0]        req,
        input logic [trl_pkg::INDEX_W-1:0]      idx,
        input logic [trl_pkg::FIELD_TIME_W-1:0] sent,
        input logic [trl_pkg::FIELD_TIME_W-1:0] now);
        outcome_t                         res;
        logic [trl_pkg::INDEX_W-1:0]      h;
        logic [trl_pkg::FIELD_TIME_W-1:0] age;
        res = '0;
        res.status = trl_pkg::STATUS_OK;
        case (req)
            trl_pkg::REQ_APPEND, trl_pkg::REQ_PREPEND:
            begin
                if (ring_member[idx])
                    res.status = trl_pkg::STATUS_LINKED;
                else
                begin
                    ring_stamp[idx] = sent;
                    ring_insert(idx, req == trl_pkg::REQ_PREPEND);
                end
            end
            trl_pkg::REQ_UNLINK:
            begin
                if (ring_member[idx])
                    ring_remove(idx);
                else
                    res.status = trl_pkg::STATUS_ABSENT;
            end
            default:
            begin
                if (ring_filled)
                begin
                    h = ring_head;
                    age = now - ring_stamp[h];
                    if (age >= timeout_limit)
                    begin
                        ring_remove(h);
                        res.taken = 1'b1;
                        res.taken_idx = h;
                    end
                end
            end
        endcase
        res.empty = !ring_filled;
        return res;
    endfunction

    function automatic logic [trl_pkg::INDEX_W-1:0] find_entry(input bit want_member);
        logic [trl_pkg::INDEX_W-1:0] idx;
        logic [31:0]                 draw;
        draw = $urandom;
        idx = draw[trl_pkg::INDEX_W-1:0];
        while (ring_member[idx] != want_member)
            idx = idx + 1'b1;
        return idx;
    endfunction

    task automatic send_request(input logic [trl_pkg::REQ_W-1:0] req,
                                input logic [trl_pkg::INDEX_W-1:0] idx,
                                input logic [trl_pkg::FIELD_TIME_W-1:0] sent,
                                input logic [trl_pkg::FIELD_TIME_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {now, sent, idx};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_outcomes.push_back(predict_list_outcome(req, idx, sent, now));
    endtask

    task automatic settle_requests();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [trl_pkg::FIELD_TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        timeout_limit = value;
    endtask

    // mostly well-formed list traffic, some noise
    task automatic send_list_activity();
        int                               pick;
        logic [31:0]                      draw;
        logic [trl_pkg::REQ_W-1:0]        req;
        logic [trl_pkg::INDEX_W-1:0]      idx;
        logic [trl_pkg::FIELD_TIME_W-1:0] sent;
        logic [trl_pkg::FIELD_TIME_W-1:0] now;
        pick = $urandom_range(0, 99);
        req  = trl_pkg::REQ_TAKE;
        draw = $urandom;
        idx  = draw[trl_pkg::INDEX_W-1:0];
        sent = $urandom;
        now  = $urandom;
        if (pick < 8)
        begin
            draw = $urandom_range(0, 3);
            req  = draw[trl_pkg::REQ_W-1:0];
        end
        else if (ring_size == 0 || (pick < 50 && ring_size < 240))
        begin
            idx  = find_entry(1'b0);
            req  = ($urandom_range(0, 3) == 0) ? trl_pkg::REQ_PREPEND : trl_pkg::REQ_APPEND;
            sent = clock_ms;
            clock_ms = clock_ms + $urandom_range(0, step_max);
        end
        else if (pick < 70)
        begin
            req = trl_pkg::REQ_UNLINK;
            idx = find_entry(1'b1);
        end
        else if (pick < 73)
        begin
            req = ($urandom_range(0, 1) == 0) ? trl_pkg::REQ_PREPEND : trl_pkg::REQ_APPEND;
            idx = find_entry(1'b1);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: now = clock_ms;
                1: now = ring_stamp[ring_head] + timeout_limit;
                2: now = ring_stamp[ring_head] + timeout_limit - 1'b1;
                default: ;
            endcase
            clock_ms = clock_ms + $urandom_range(0, step_max);
        end
        send_request(req, idx, sent, now);
    endtask

    task automatic test_directed();
        write_timeout(32'd10);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_UNLINK, 8'd0, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd0, 32'hFFFF_FFFA, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd0, 32'd5, 32'd0);
        send_request(trl_pkg::REQ_PREPEND, 8'd0, 32'd5, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd255, 32'd0, 32'hFFFF_FFFF);
        send_request(trl_pkg::REQ_PREPEND, 8'd128, 32'hFFFF_FFFF, 32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd255, 32'd0, 32'd3);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd9);
        send_request(trl_pkg::REQ_UNLINK, 8'd255, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_UNLINK, 8'd0, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(trl_pkg::REQ_PREPEND, 8'd7, 32'd100, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd8, 32'd100, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd9, 32'd100, 32'd0);
        send_request(trl_pkg::REQ_UNLINK, 8'd8, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_UNLINK, 8'd7, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'hFFFF_FFFF);
        settle_requests();
        write_timeout(32'hFFFF_FFFF);
        send_request(trl_pkg::REQ_APPEND, 8'd42, 32'd500, 32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd500);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd499);
        settle_requests();
        write_timeout(32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd0);
        send_request(trl_pkg::REQ_APPEND, 8'd1, 32'd123, 32'd0);
        send_request(trl_pkg::REQ_TAKE, 8'd0, 32'd0, 32'd123);
        settle_requests();
    endtask

    task automatic test_random_traffic();
        logic [trl_pkg::FIELD_TIME_W-1:0] limits [6];
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = 32'd50;
        limits[4] = $urandom_range(100, 5000);
        limits[5] = 32'h8000_0000;
        clock_ms = $urandom;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_timeout(limits[ph]);
            step_max = (limits[ph] >> 3) + 1;
            steady = (ph % 3 == 2);
            repeat (PHASE_ITEMS) send_list_activity();
            settle_requests();
        end
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req <= hold_req + 1;
        steady = 1'b1;
        repeat (50) send_list_activity();
        steady = 1'b0;
        settle_requests();
    endtask

    // receiver ready pattern, plus long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            hold_seen   <= 0;
            stall_clock <= 0;
            stall_mode  <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            stall_clock <= stall_clock + 1;
            if (stall_clock % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= stall_clock[0];
            endcase
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result item with nothing expected, actual %h/%h",
                         $time, m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                report_field("taken_valid", want.taken, m_tdata[0]);
                report_field("taken_index", want.taken_idx, m_tdata[8:1]);
                report_field("is_empty", want.empty, m_tdata[9]);
                report_field("status_code", want.status, m_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_output_backpressure();
        settle_requests();
        repeat (16) @(posedge clk);
        if (failures == 0 && expected_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
